### hw/rtl/bhpq_pkg.sv
// bhpq_pkg: types, codes and the ordering function of the heap priority queue
// no dependencies; used by the interfaces, the heap cell and the top level
`default_nettype none
package bhpq_pkg;

   localparam int DepthDefault = 64;
   localparam int SeqWidth     = 32;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_POLL   = 2'd1,
      OP_PEEK   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   typedef enum logic {
      REG_ORDER_MODE = 1'b0,
      REG_CAPACITY   = 1'b1
   } reg_index_type;

   // one heap entry
   typedef struct packed {
      logic [7:0]          id;
      logic [31:0]         key;
      logic [SeqWidth-1:0] seq;
   } slot_type;

   // what a cell loads in the coming cycle
   typedef enum logic [2:0] {
      SEL_HOLD,
      SEL_NEW,
      SEL_LAST,
      SEL_PARENT,
      SEL_LEFT,
      SEL_RIGHT
   } sel_type;

   typedef struct packed {
      sel_type  sel;
      logic     mode;
   } cell_ctrl_type;

   // true when a must leave strictly before b (sequence compare is wrap-aware)
   function automatic logic goes_before(input logic mode, input slot_type a,
                                        input slot_type b);
      logic [SeqWidth-1:0] d;
      logic                r;
      d = b.seq - a.seq;
      if (!mode && (a.key != b.key)) begin
         r = (a.key < b.key);
      end else begin
         r = (d != '0) && !d[SeqWidth-1];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/bhpq_req_if.sv
// bhpq_req_if: request channel of the heap priority queue
// depends on bhpq_pkg
`default_nettype none
interface bhpq_req_if;
   logic                valid;
   logic                ready;
   bhpq_pkg::op_type    operation;
   logic [7:0]          item_id;
   logic [31:0]         item_key;

   modport source (output valid, operation, item_id, item_key, input ready);
   modport sink   (input valid, operation, item_id, item_key, output ready);
endinterface
`default_nettype wire

### hw/rtl/bhpq_rsp_if.sv
// bhpq_rsp_if: result channel of the heap priority queue
// depends on bhpq_pkg
`default_nettype none
interface bhpq_rsp_if;
   logic                   valid;
   logic                   ready;
   bhpq_pkg::status_type   status;
   logic [7:0]             first_id;
   logic [6:0]             occupancy;

   modport source (output valid, status, first_id, occupancy, input ready);
   modport sink   (input valid, status, first_id, occupancy, output ready);
endinterface
`default_nettype wire

### hw/rtl/bhpq_cell.sv
// bhpq_cell: one heap slot, compares itself with its parent and left sibling
// depends on bhpq_pkg
`default_nettype none
module bhpq_cell #(
   parameter int INDEX = 0
) (
   input  wire logic               clock,
   input  wire bhpq_pkg::cell_ctrl_type ctrl,
   input  wire bhpq_pkg::slot_type new_slot,
   input  wire bhpq_pkg::slot_type last_slot,
   input  wire bhpq_pkg::slot_type parent_slot,
   input  wire bhpq_pkg::slot_type left_slot,
   input  wire bhpq_pkg::slot_type right_slot,
   input  wire bhpq_pkg::slot_type sib_slot,
   output bhpq_pkg::slot_type      slot,
   output logic                    before_parent,
   output logic                    before_sib
);

   bhpq_pkg::slot_type slot_ff, slot_in;

   // next content from the selected neighbor
   always_comb begin
      unique case (ctrl.sel)
         bhpq_pkg::SEL_NEW:    slot_in = new_slot;
         bhpq_pkg::SEL_LAST:   slot_in = last_slot;
         bhpq_pkg::SEL_PARENT: slot_in = parent_slot;
         bhpq_pkg::SEL_LEFT:   slot_in = left_slot;
         bhpq_pkg::SEL_RIGHT:  slot_in = right_slot;
         default:              slot_in = slot_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   // order against the parent and, for a right child, the left sibling
   always_comb begin
      before_parent = (INDEX > 0) &&
                      bhpq_pkg::goes_before(ctrl.mode, slot_ff, parent_slot);
      before_sib    = (INDEX > 0) && (INDEX % 2 == 0) &&
                      bhpq_pkg::goes_before(ctrl.mode, slot_ff, sib_slot);
   end

   assign slot = slot_ff;

endmodule
`default_nettype wire

### hw/rtl/binary_heap_priority_queue_core.sv
// binary_heap_priority_queue_core: min-heap priority queue built as a row of heap cells
// depends on bhpq_pkg, bhpq_req_if, bhpq_rsp_if and bhpq_cell
//
// channel  direction  payload
// req_ch   in         operation, item_id, item_key
// rsp_ch   out        status, first_id, occupancy
// csr_*    in         order_mode (index 0), capacity_limit (index 1)
//
// The result is known in the accept cycle and goes to a holding register, then the output
// register. An insert then sifts up and a poll sifts down, one heap level per cycle.
// Reset is synchronous; it clears state, count and valid flags and sets the sequence to 1,
// order mode to 0 and capacity to 64; slot contents and held result data are not cleared.
// Requests stall while a sift runs or a result still waits in the holding register.
`default_nettype none
module binary_heap_priority_queue_core #(
   parameter int DEPTH = bhpq_pkg::DepthDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   bhpq_req_if.sink         req_ch,
   bhpq_rsp_if.source       rsp_ch,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [6:0]  csr_data
);

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {IDLE, SIFT_UP, SIFT_DOWN} state_type;

   state_type                  state_ff;
   logic [DEPTH-1:0]           active_ff, active_in;
   logic [CW-1:0]              count_ff;
   logic [bhpq_pkg::SeqWidth-1:0] seq_ff;
   logic                       mode_ff;
   logic [6:0]                 cap_ff;
   logic                       pend_ff;
   bhpq_pkg::status_type       hold_status_ff;
   logic [7:0]                 hold_first_ff;
   logic [6:0]                 hold_occ_ff;
   logic                       out_valid_ff;
   bhpq_pkg::status_type       out_status_ff;
   logic [7:0]                 out_first_ff;
   logic [6:0]                 out_occ_ff;

   bhpq_pkg::slot_type         slots [DEPTH];
   bhpq_pkg::slot_type         last_slot, new_slot;
   bhpq_pkg::cell_ctrl_type    ctrl [DEPTH];
   logic [DEPTH-1:0]           bpar, bsib, swap_up, swapd_l, swapd_r;

   logic accept, full, empty, insert_go, poll_go, out_free;

   assign accept    = req_ch.valid && req_ch.ready;
   assign full      = ({{(CW > 7 ? CW - 7 : 0){1'b0}}, cap_ff} <= CW'(0)) ? 1'b1 :
                      ((32'(count_ff) >= 32'(cap_ff)) || (32'(count_ff) >= DEPTH));
   assign empty     = (count_ff == '0);
   assign insert_go = accept && (req_ch.operation == bhpq_pkg::OP_INSERT) && !full;
   assign poll_go   = accept && (req_ch.operation == bhpq_pkg::OP_POLL) && !empty;
   assign out_free  = !out_valid_ff || rsp_ch.ready;

   assign req_ch.ready = (state_ff == IDLE) && !pend_ff;

   // new entry from the request
   always_comb begin
      new_slot.id  = req_ch.item_id;
      new_slot.key = req_ch.item_key;
      new_slot.seq = seq_ff;
   end

   // last entry, picked by the current count
   always_comb begin
      last_slot = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (32'(count_ff) == i + 1) last_slot = last_slot | slots[i];
      end
   end

   // cell row with fixed parent, child and sibling wiring
   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      localparam int  PI   = (j > 0) ? (j - 1) / 2 : 0;
      localparam bit  HASL = (2 * j + 1) < DEPTH;
      localparam bit  HASR = (2 * j + 2) < DEPTH;
      localparam int  LI   = HASL ? 2 * j + 1 : j;
      localparam int  RI   = HASR ? 2 * j + 2 : j;
      localparam int  SI   = (j > 0 && j % 2 == 0) ? j - 1 : j;

      logic has_l, has_r, best_r, child_up_l, child_up_r, parent_down;

      assign has_l  = HASL && (32'(count_ff) > 2 * j + 1);
      assign has_r  = HASR && (32'(count_ff) > 2 * j + 2);
      assign best_r = has_r && bsib[RI];

      assign swap_up[j] = (state_ff == SIFT_UP) && active_ff[j] && (j > 0) && bpar[j];
      assign swapd_l[j] = (state_ff == SIFT_DOWN) && active_ff[j] && has_l && !best_r &&
                          bpar[LI];
      assign swapd_r[j] = (state_ff == SIFT_DOWN) && active_ff[j] && best_r && bpar[RI];

      assign child_up_l  = HASL && swap_up[LI];
      assign child_up_r  = HASR && swap_up[RI];
      assign parent_down = (j > 0) && ((j % 2 == 1) ? swapd_l[PI] : swapd_r[PI]);

      // select of this cell
      always_comb begin
         ctrl[j].mode = mode_ff;
         priority if (insert_go && (32'(count_ff) == j)) begin
            ctrl[j].sel = bhpq_pkg::SEL_NEW;
         end else if (poll_go && (j == 0)) begin
            ctrl[j].sel = bhpq_pkg::SEL_LAST;
         end else if (swap_up[j] || parent_down) begin
            ctrl[j].sel = bhpq_pkg::SEL_PARENT;
         end else if (child_up_l || swapd_l[j]) begin
            ctrl[j].sel = bhpq_pkg::SEL_LEFT;
         end else if (child_up_r || swapd_r[j]) begin
            ctrl[j].sel = bhpq_pkg::SEL_RIGHT;
         end else begin
            ctrl[j].sel = bhpq_pkg::SEL_HOLD;
         end
      end

      // sift position moves with the swap
      always_comb begin
         priority if (insert_go) begin
            active_in[j] = (32'(count_ff) == j);
         end else if (poll_go) begin
            active_in[j] = (j == 0);
         end else begin
            active_in[j] = child_up_l || child_up_r || parent_down;
         end
      end

      bhpq_cell #(.INDEX(j)) u_cell (
         .clock        (clock),
         .ctrl         (ctrl[j]),
         .new_slot     (new_slot),
         .last_slot    (last_slot),
         .parent_slot  (slots[PI]),
         .left_slot    (slots[LI]),
         .right_slot   (slots[RI]),
         .sib_slot     (slots[SI]),
         .slot         (slots[j]),
         .before_parent(bpar[j]),
         .before_sib   (bsib[j])
      );
   end

   // control state, result holding and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         active_ff    <= '0;
         count_ff     <= '0;
         seq_ff       <= bhpq_pkg::SeqWidth'(1);
         mode_ff      <= 1'b0;
         cap_ff       <= 7'd64;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;

         // configuration writes
         if (csr_write) begin
            unique case (bhpq_pkg::reg_index_type'(csr_index))
               bhpq_pkg::REG_ORDER_MODE: mode_ff <= csr_data[0];
               bhpq_pkg::REG_CAPACITY:   cap_ff  <= csr_data;
               default: ;
            endcase
         end

         unique case (state_ff)
            IDLE: begin
               if (insert_go) begin
                  state_ff <= SIFT_UP;
                  count_ff <= count_ff + CW'(1);
                  seq_ff   <= seq_ff + bhpq_pkg::SeqWidth'(1);
               end else if (poll_go) begin
                  state_ff <= SIFT_DOWN;
                  count_ff <= count_ff - CW'(1);
               end
            end
            SIFT_UP: begin
               if (swap_up == '0) state_ff <= IDLE;
            end
            SIFT_DOWN: begin
               if ((swapd_l | swapd_r) == '0) state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase

         // result of the accepted item
         if (accept) begin
            pend_ff <= 1'b1;
            unique case (req_ch.operation)
               bhpq_pkg::OP_INSERT: begin
                  hold_status_ff <= full ? bhpq_pkg::ST_FULL : bhpq_pkg::ST_OK;
                  hold_first_ff  <= 8'd0;
                  hold_occ_ff    <= full ? 7'(count_ff) : 7'(count_ff + CW'(1));
               end
               bhpq_pkg::OP_POLL, bhpq_pkg::OP_PEEK: begin
                  hold_status_ff <= empty ? bhpq_pkg::ST_EMPTY : bhpq_pkg::ST_OK;
                  hold_first_ff  <= empty ? 8'd0 : slots[0].id;
                  hold_occ_ff    <= poll_go ? 7'(count_ff - CW'(1)) : 7'(count_ff);
               end
               default: begin
                  hold_status_ff <= bhpq_pkg::ST_OK;
                  hold_first_ff  <= 8'd0;
                  hold_occ_ff    <= 7'(count_ff);
               end
            endcase
         end else if (pend_ff && out_free) begin
            pend_ff <= 1'b0;
         end

         // output register
         if (out_free) begin
            out_valid_ff <= pend_ff;
            if (pend_ff) begin
               out_status_ff <= hold_status_ff;
               out_first_ff  <= hold_first_ff;
               out_occ_ff    <= hold_occ_ff;
            end
         end
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.status    = out_status_ff;
   assign rsp_ch.first_id  = out_first_ff;
   assign rsp_ch.occupancy = out_occ_ff;

endmodule
`default_nettype wire

### tb/sv/binary_heap_priority_queue_core_test.sv
// binary_heap_priority_queue_core_test: self-checking bench for the heap priority queue
// depends on bhpq_pkg, bhpq_req_if, bhpq_rsp_if and binary_heap_priority_queue_core
// a directed table, then random phases under several order modes and capacities
`default_nettype none
module binary_heap_priority_queue_core_test;
   import bhpq_pkg::*;

   localparam int HeapDepth = 64;
   localparam int IdleLimit = 3000;
   localparam int LongHold  = 400;
   localparam int DrainWait = 16;

   typedef struct {
      op_type      op;
      logic [7:0]  id;
      logic [31:0] key;
      bit          typed;
      status_type  st;
      logic [7:0]  fid;
      logic [6:0]  occ;
   } stim_row_type;

   typedef struct {
      status_type st;
      logic [7:0] fid;
      logic [6:0] occ;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic csr_index = 1'b0;
   logic [6:0] csr_data = '0;

   bhpq_req_if req_if ();
   bhpq_rsp_if rsp_if ();

   binary_heap_priority_queue_core #(.DEPTH(HeapDepth)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow heap
   logic [7:0]  heap_id  [HeapDepth];
   logic [31:0] heap_key [HeapDepth];
   logic [31:0] heap_seq [HeapDepth];
   int unsigned heap_count;
   logic [31:0] seq_next;
   logic        mode_sh;
   logic [6:0]  cap_sh;

   outcome_type pending_outcomes[$];
   int errors;
   int n_accepted, n_results, n_refused, n_empty, n_polled;

   // sender side of the typed expectation, moved with the payload
   logic        row_typed = 1'b0;
   outcome_type row_outcome;

   bit quiet;
   bit long_hold_req;

   function automatic bit leaves_first(int unsigned a, int unsigned b);
      logic [31:0] d;
      d = heap_seq[b] - heap_seq[a];
      if (!mode_sh && heap_key[a] != heap_key[b]) return heap_key[a] < heap_key[b];
      return (d != 0) && !d[31];
   endfunction

   function automatic void swap_entries(int unsigned a, int unsigned b);
      logic [7:0]  ti;
      logic [31:0] tk, ts;
      ti = heap_id[a];  heap_id[a]  = heap_id[b];  heap_id[b]  = ti;
      tk = heap_key[a]; heap_key[a] = heap_key[b]; heap_key[b] = tk;
      ts = heap_seq[a]; heap_seq[a] = heap_seq[b]; heap_seq[b] = ts;
   endfunction

   // apply one request to the shadow heap and return its outcome
   function automatic outcome_type heap_apply(op_type op, logic [7:0] id, logic [31:0] key);
      outcome_type r;
      int unsigned cap, p, par, lc, best;
      r.st = ST_OK; r.fid = '0;
      cap = (cap_sh < HeapDepth) ? cap_sh : HeapDepth;
      if (op == OP_INSERT) begin
         if (heap_count >= cap) begin
            r.st = ST_FULL;
         end else begin
            p = heap_count;
            heap_id[p] = id; heap_key[p] = key; heap_seq[p] = seq_next;
            seq_next = seq_next + 1;
            heap_count = p + 1;
            while (p > 0) begin
               par = (p - 1) / 2;
               if (!leaves_first(p, par)) break;
               swap_entries(p, par);
               p = par;
            end
         end
      end else if (op == OP_POLL || op == OP_PEEK) begin
         if (heap_count == 0) begin
            r.st = ST_EMPTY;
         end else begin
            r.fid = heap_id[0];
            if (op == OP_POLL) begin
               heap_count = heap_count - 1;
               heap_id[0] = heap_id[heap_count];
               heap_key[0] = heap_key[heap_count];
               heap_seq[0] = heap_seq[heap_count];
               p = 0;
               forever begin
                  lc = 2 * p + 1;
                  if (lc >= heap_count) break;
                  best = lc;
                  if (lc + 1 < heap_count && leaves_first(lc + 1, lc)) best = lc + 1;
                  if (!leaves_first(best, p)) break;
                  swap_entries(p, best);
                  p = best;
               end
            end
         end
      end
      r.occ = heap_count[6:0];
      return r;
   endfunction

   // request monitor: predict on every accepted item
   always @(posedge clock) begin
      outcome_type o;
      if (!reset && req_if.valid && req_if.ready) begin
         o = heap_apply(req_if.operation, req_if.item_id, req_if.item_key);
         if (row_typed) o = row_outcome;
         pending_outcomes.push_back(o);
         n_accepted++;
      end
   end

   // result checker
   always @(posedge clock) begin
      outcome_type o;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         n_results++;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: result with nothing expected: st %0d id %0d occ %0d", $time,
                     rsp_if.status, rsp_if.first_id, rsp_if.occupancy);
            errors++;
         end else begin
            o = pending_outcomes.pop_front();
            if (rsp_if.status !== o.st) begin
               $display("%0t: status expected %0d actual %0d", $time, o.st, rsp_if.status);
               errors++;
            end
            if (rsp_if.first_id !== o.fid) begin
               $display("%0t: first_id expected %0d actual %0d", $time, o.fid,
                        rsp_if.first_id);
               errors++;
            end
            if (rsp_if.occupancy !== o.occ) begin
               $display("%0t: occupancy expected %0d actual %0d", $time, o.occ,
                        rsp_if.occupancy);
               errors++;
            end
            if (o.st == ST_FULL) n_refused++;
            if (o.st == ST_EMPTY) n_empty++;
            if (o.st == ST_OK && o.fid != 0) n_polled++;
         end
      end
   end

   // watchdog on cycles without any handshake
   int idle_cycles;
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("%0t: no progress for %0d cycles", $time, IdleLimit);
            $display("binary_heap_priority_queue_core_test: errors");
            $finish;
         end
      end
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      int r;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_if.ready <= 1'b0;
            repeat (LongHold) @(posedge clock);
            long_hold_req = 0;
            rsp_if.ready <= 1'b1;
         end else if (quiet) begin
            rsp_if.ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_if.ready <= 1'b1;
            end else begin
               rsp_if.ready <= 1'b0;
               repeat ((r < 92) ? $urandom_range(0, 2) : $urandom_range(8, 40))
                  @(posedge clock);
            end
         end
      end
   end

   task automatic send_item(op_type op, logic [7:0] id, logic [31:0] key, bit typed,
                            outcome_type o);
      int r;
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.item_id   <= id;
      req_if.item_key  <= key;
      row_typed        <= typed;
      row_outcome      <= o;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      r = $urandom_range(0, 99);
      if (!quiet && r >= 55) begin
         req_if.valid <= 1'b0;
         repeat ((r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 50)) @(posedge clock);
      end
   endtask

   // lower valid and wait until every result is back, plus the sift latency
   task automatic drain_all();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [6:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == REG_ORDER_MODE) mode_sh = value[0];
      else cap_sh = value;
   endtask

   function automatic outcome_type mk(status_type st, logic [7:0] fid, logic [6:0] occ);
      outcome_type o;
      o.st = st; o.fid = fid; o.occ = occ;
      return o;
   endfunction

   stim_row_type dir_rows[$];

   function automatic void add_row(op_type op, logic [7:0] id, logic [31:0] key, bit typed,
                                   outcome_type o);
      stim_row_type s;
      s.op = op; s.id = id; s.key = key; s.typed = typed;
      s.st = o.st; s.fid = o.fid; s.occ = o.occ;
      dir_rows.push_back(s);
   endfunction

   function automatic logic [31:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return $urandom_range(0, 15);
      if (r < 80) return $urandom;
      return (r < 90) ? 32'h0 : 32'hFFFF_FFFF;
   endfunction

   initial begin
      outcome_type none_o;
      int r, fill_bias, n_items;
      op_type op;
      logic [6:0] phase_mode[8] = '{7'd0, 7'd1, 7'd0, 7'd0, 7'd1, 7'd0, 7'd1, 7'd0};
      logic [6:0] phase_cap[8]  = '{7'd64, 7'd64, 7'd3, 7'd0, 7'd127, 7'd1, 7'd65, 7'd64};

      req_if.valid     <= 1'b0;
      req_if.operation <= OP_NONE;
      req_if.item_id   <= '0;
      req_if.item_key  <= '0;
      heap_count = 0; seq_next = 1; mode_sh = 1'b0; cap_sh = 7'd64;
      none_o = mk(ST_OK, 8'd0, 7'd0);

      // directed rows: empty queue, no-op code, key extremes, key ties
      add_row(OP_POLL,   8'h00, 32'h0,         1, mk(ST_EMPTY, 8'd0, 7'd0));
      add_row(OP_PEEK,   8'h00, 32'h0,         1, mk(ST_EMPTY, 8'd0, 7'd0));
      add_row(OP_NONE,   8'hFF, 32'hFFFF_FFFF, 1, mk(ST_OK, 8'd0, 7'd0));
      add_row(OP_INSERT, 8'hFF, 32'hFFFF_FFFF, 1, mk(ST_OK, 8'd0, 7'd1));
      add_row(OP_INSERT, 8'h00, 32'h0,         1, mk(ST_OK, 8'd0, 7'd2));
      add_row(OP_INSERT, 8'h5A, 32'h0,         0, none_o);
      add_row(OP_INSERT, 8'hA5, 32'h7,         0, none_o);
      add_row(OP_INSERT, 8'h3C, 32'h8000_0000, 0, none_o);
      add_row(OP_PEEK,   8'h00, 32'h0,         1, mk(ST_OK, 8'd0, 7'd5));
      add_row(OP_NONE,   8'h00, 32'h0,         1, mk(ST_OK, 8'd0, 7'd5));
      add_row(OP_POLL,   8'h00, 32'h0,         1, mk(ST_OK, 8'd0, 7'd4));
      add_row(OP_POLL,   8'h00, 32'h0,         0, none_o);
      add_row(OP_INSERT, 8'hC3, 32'h7,         0, none_o);
      add_row(OP_PEEK,   8'h00, 32'h0,         0, none_o);
      add_row(OP_POLL,   8'h00, 32'h0,         0, none_o);
      add_row(OP_POLL,   8'h00, 32'h0,         0, none_o);
      add_row(OP_POLL,   8'h00, 32'h0,         0, none_o);
      add_row(OP_POLL,   8'h00, 32'h0,         1, mk(ST_OK, 8'hFF, 7'd0));
      add_row(OP_POLL,   8'h00, 32'h0,         1, mk(ST_EMPTY, 8'd0, 7'd0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_item(dir_rows[i].op, dir_rows[i].id, dir_rows[i].key, dir_rows[i].typed,
                   mk(dir_rows[i].st, dir_rows[i].fid, dir_rows[i].occ));
      drain_all();

      // random phases; the queue is not emptied in between, so a lower capacity
      // can land below the current occupancy
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(REG_ORDER_MODE, phase_mode[ph]);
         write_reg(REG_CAPACITY, phase_cap[ph]);
         quiet = (ph == 2);
         n_items = 0;
         while (n_items < 205) begin
            if (n_items % 60 == 0) fill_bias = $urandom_range(25, 75);
            if (ph == 0 && n_items == 100) long_hold_req = 1;
            if (ph == 4 && n_items == 100) drain_all();
            r = $urandom_range(0, 99);
            if (r < 4) op = OP_NONE;
            else if (r < fill_bias) op = OP_INSERT;
            else if (r < fill_bias + (100 - fill_bias) * 3 / 4) op = OP_POLL;
            else op = OP_PEEK;
            send_item(op, 8'($urandom), pick_key(), 0, none_o);
            if (op != OP_NONE) n_items++;
         end
         drain_all();
      end

      $display("items %0d, results %0d: %0d removed or seen, %0d refused full, %0d empty",
               n_accepted, n_results, n_polled, n_refused, n_empty);
      $display("order modes key and arrival, capacities 0 to 127, long output stall");
      if (errors == 0 && pending_outcomes.size() == 0)
         $display("binary_heap_priority_queue_core_test: clean");
      else
         $display("binary_heap_priority_queue_core_test: errors");
      $finish;
   end

endmodule
`default_nettype wire

### files.f
hw/rtl/bhpq_pkg.sv
hw/rtl/bhpq_req_if.sv
hw/rtl/bhpq_rsp_if.sv
hw/rtl/bhpq_cell.sv
hw/rtl/binary_heap_priority_queue_core.sv
tb/sv/binary_heap_priority_queue_core_test.sv
